>>> src/vpf_pkg.sv
// ============================================================================
// vpf_pkg - shared types and constants for the voxel parity fill block
// Volume limits, derived widths, register indexes and the position record
// handed from the scan counters to the parity core.
// ============================================================================
`default_nettype none

package vpf_pkg;

    // Largest volume the parity stores are sized for
    localparam int MAX_X = 32;
    localparam int MAX_Y = 32;
    localparam int MAX_Z = 32;

    // Width of a dimension register as seen on the configuration port
    localparam int DIM_W = 6;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

    // Position counter widths (at least one bit each)
    localparam int X_W = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int Y_W = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

    // Width for end-of-line compares: holds a clamped dimension and position + 1
    localparam int MAX_DIM = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                             : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int CMP_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;

    // z parity plane: one bit per (x, y) position
    localparam int PLANE_DEPTH = MAX_X * MAX_Y;
    localparam int PLANE_AW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
    localparam logic [PLANE_AW-1:0] ROW_STRIDE = PLANE_AW'(MAX_X);
    localparam logic [PLANE_AW-1:0] PLANE_LAST = PLANE_AW'(PLANE_DEPTH - 1);

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    // Position of one voxel in the scan, with its plane address
    typedef struct packed {
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [Z_W-1:0]      z;
        logic [PLANE_AW-1:0] addr;
        logic                last;
    } vpf_item_t;

    // Core status seen by the top level
    typedef struct packed {
        logic clearing;
        logic s1_valid;
        logic can_take;
    } vpf_status_t;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                   input int maxv);
        logic [CMP_W-1:0] r;
        if (d == '0)
            r = CMP_W'(1);
        else if (CMP_W'(d) > CMP_W'(maxv))
            r = CMP_W'(maxv);
        else
            r = CMP_W'(d);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/vpf_if.sv
// ============================================================================
// vpf_if - valid/ready channels of the voxel parity fill block
// One interface for the incoming voxel stream and one for the results.
// ============================================================================
`default_nettype none

interface vpf_in_if;
    logic valid;
    logic ready;
    logic surface;

    modport source (output valid, output surface, input ready);
    modport sink   (input valid, input surface, output ready);
endinterface

interface vpf_out_if;
    logic valid;
    logic ready;
    logic filled;
    logic last_voxel;

    modport source (output valid, output filled, output last_voxel, input ready);
    modport sink   (input valid, input filled, input last_voxel, output ready);
endinterface

`default_nettype wire

>>> src/vpf_ram.sv
// ============================================================================
// vpf_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old data
// when both touch the same address in the same cycle.
// ============================================================================
`default_nettype none

module vpf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/vpf_scan.sv
// ============================================================================
// vpf_scan - dimension registers and raster position counters
// Hold the x, y, z position of the next voxel and advance it per transfer.
// ============================================================================
`default_nettype none

module vpf_scan (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [vpf_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [vpf_pkg::DIM_W-1:0]      wr_data,
    input  wire logic                           accept,
    output vpf_pkg::vpf_item_t                  item
);
    import vpf_pkg::*;

    logic [DIM_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [X_W-1:0]   pos_x_reg, pos_x_next;
    logic [Y_W-1:0]   pos_y_reg, pos_y_next;
    logic [Z_W-1:0]   pos_z_reg, pos_z_next;
    logic [CMP_W-1:0] dx, dy, dz;
    logic             end_x, end_y, end_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= DIM_RESET;
            dim_y_reg <= DIM_RESET;
            dim_z_reg <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DIM_X: dim_x_reg <= wr_data;
                REG_DIM_Y: dim_y_reg <= wr_data;
                REG_DIM_Z: dim_z_reg <= wr_data;
                default:   ;
            endcase
        end
    end

    assign dx = clamp_dim(dim_x_reg, MAX_X);
    assign dy = clamp_dim(dim_y_reg, MAX_Y);
    assign dz = clamp_dim(dim_z_reg, MAX_Z);

    // A counter at or past its new last index counts as at the end
    assign end_x = (CMP_W'(pos_x_reg) + CMP_W'(1)) >= dx;
    assign end_y = (CMP_W'(pos_y_reg) + CMP_W'(1)) >= dy;
    assign end_z = (CMP_W'(pos_z_reg) + CMP_W'(1)) >= dz;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (!end_x)
        begin
            pos_x_next = pos_x_reg + X_W'(1);
        end
        else
        begin
            pos_x_next = '0;
            if (!end_y)
            begin
                pos_y_next = pos_y_reg + Y_W'(1);
            end
            else
            begin
                pos_y_next = '0;
                pos_z_next = end_z ? '0 : pos_z_reg + Z_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (accept)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    always_comb
    begin
        item.x    = pos_x_reg;
        item.y    = pos_y_reg;
        item.z    = pos_z_reg;
        item.addr = PLANE_AW'(pos_y_reg) * ROW_STRIDE + PLANE_AW'(pos_x_reg);
        item.last = end_x && end_y && end_z;
    end

endmodule

`default_nettype wire

>>> src/vpf_core.sv
// ============================================================================
// vpf_core - parity stores, working stage and result register
// Toggle the x, y and z parities for one voxel per cycle while results are
// taken, and register the filled flag; clear the z plane after reset.
// ============================================================================
`default_nettype none

module vpf_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                surface,
    input  wire vpf_pkg::vpf_item_t  item,
    output vpf_pkg::vpf_status_t     status,
    vpf_out_if.source                result
);
    import vpf_pkg::*;

    // Clearing pass over the z plane
    logic                clr_active_reg;
    logic [PLANE_AW-1:0] clr_addr_reg;

    // Working stage
    logic       s1_valid_reg;
    vpf_item_t  s1_item_reg;
    logic       s1_surface_reg;

    // Parity stores held in flops
    logic             x_parity_reg;
    logic [MAX_X-1:0] y_row_reg;

    // Last plane write, forwarded over a same-cycle read
    logic                fwd_valid_reg;
    logic [PLANE_AW-1:0] fwd_addr_reg;
    logic                fwd_data_reg;

    // Result register
    logic out_valid_reg, out_filled_reg, out_last_reg;

    logic                ram_we;
    logic [PLANE_AW-1:0] ram_waddr;
    logic                ram_wdata;
    logic                ram_rdata;
    logic                z_stored;
    logic                px, py, pz;
    logic                s1_adv;

    vpf_ram #(
        .WIDTH (1),
        .DEPTH (PLANE_DEPTH),
        .AW    (PLANE_AW)
    ) u_plane (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (item.addr),
        .rdata (ram_rdata)
    );

    assign s1_adv = s1_valid_reg && (!out_valid_reg || result.ready);

    assign z_stored = (fwd_valid_reg && fwd_addr_reg == s1_item_reg.addr)
                      ? fwd_data_reg : ram_rdata;

    // Stored parity counts as zero on the first voxel of its line
    assign px = ((s1_item_reg.x == '0) ? 1'b0 : x_parity_reg) ^ s1_surface_reg;
    assign py = ((s1_item_reg.y == '0) ? 1'b0 : y_row_reg[s1_item_reg.x]) ^ s1_surface_reg;
    assign pz = ((s1_item_reg.z == '0) ? 1'b0 : z_stored) ^ s1_surface_reg;

    assign ram_we    = clr_active_reg || s1_adv;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_item_reg.addr;
    assign ram_wdata = clr_active_reg ? 1'b0 : pz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == PLANE_LAST)
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + PLANE_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            x_parity_reg  <= 1'b0;
            y_row_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                x_parity_reg               <= px;
                y_row_reg[s1_item_reg.x]   <= py;
                fwd_valid_reg              <= 1'b1;
                out_valid_reg              <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg    <= item;
            s1_surface_reg <= surface;
        end
        if (s1_adv)
        begin
            fwd_addr_reg   <= s1_item_reg.addr;
            fwd_data_reg   <= pz;
            out_filled_reg <= px | py | pz;
            out_last_reg   <= s1_item_reg.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.filled     = out_filled_reg;
    assign result.last_voxel = out_last_reg;

    always_comb
    begin
        status.clearing = clr_active_reg;
        status.s1_valid = s1_valid_reg;
        status.can_take = !clr_active_reg && (!s1_valid_reg || s1_adv);
    end

endmodule

`default_nettype wire

>>> src/voxel_parity_fill_top.sv
// ============================================================================
// voxel_parity_fill_top - scanline parity fill of a voxel volume
// Surface bits in, filled bits out, one voxel per clock while results are taken.
// ============================================================================
// Surface voxel bits arrive on the voxel channel in raster order, x fastest,
// then y, then z, and each transfer gives exactly one result on the result
// channel: filled is set when the running inside parity along x, along y or
// along z (taken after this voxel's toggle) is one, and last_voxel marks the
// final voxel of the volume, after which the position counters wrap to the
// origin. The volume size comes from dim_x, dim_y and dim_z (register
// indexes 0, 1 and 2 on wr_en/wr_index/wr_data); zero acts as one and a
// value above 32 acts as 32. Change them only while the block is idle; a
// write takes effect at once and does not move the counters. Throughput is
// one voxel per clock while results are taken: the position counters form
// the plane address, the z parity plane (a 1024 x 1 RAM with registered
// read) is read on the transfer, and the toggled bit is written back when
// the working stage moves on, as the result is registered; a forwarding
// register covers a read that meets the write of the previous voxel. A
// result passes through the working stage and the result register before
// it is offered. While a result waits to be taken the voxel channel accepts
// one more voxel into the working stage and then holds ready low until the
// result moves on; voxel ready follows result ready in the same cycle. After
// reset the block clears the z plane, one entry a clock, with voxel ready
// held low; configuration writes are taken during that time.
// ============================================================================
`default_nettype none

module voxel_parity_fill_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [vpf_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [vpf_pkg::DIM_W-1:0]      wr_data,
    vpf_in_if.sink                              voxel,
    vpf_out_if.source                           result
);
    import vpf_pkg::*;

    vpf_item_t   item;
    vpf_status_t status;
    logic        accept;

    // Take a voxel whenever the working stage is free or moving on and the z plane is not being cleared
    assign voxel.ready = status.can_take;
    assign accept      = voxel.valid && status.can_take;

    // Position counters and dimension registers
    vpf_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .item     (item)
    );

    // Parity stores, working stage and result register
    vpf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .surface (voxel.surface),
        .item    (item),
        .status  (status),
        .result  (result)
    );

    // No voxel transfer while the z plane is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !voxel.ready)
    else $error("voxel accepted during plane clearing");

    // A transfer always lands in the working stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> status.s1_valid)
    else $error("accepted voxel lost before the working stage");

    // The last voxel of the volume wraps the counters to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> (item.x == '0 && item.y == '0 && item.z == '0))
    else $error("counters did not wrap after the last voxel");

endmodule

`default_nettype wire
